// ===== src/cspl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspl_pkg
// Shared types, constants and the Hermite basis function of the cardinal spline
// interpolator.
// ----------------------------------------------------------------------------
package cspl_pkg;

  localparam int CHANNELS_DEF   = 4;
  localparam int COORD_BITS_DEF = 24;

  localparam int SEGMENTS    = 16;
  localparam int SEG_LOG2    = $clog2(SEGMENTS);
  localparam int T_W         = $clog2(SEGMENTS + 1);
  localparam int COEF_W      = 3 * SEG_LOG2 + 2;
  localparam int FRAC_BITS   = 8;
  localparam int DIV_SHIFT   = FRAC_BITS + 3 * SEG_LOG2;
  localparam int AXES        = 2;
  localparam int WIN_PTS     = 4;
  localparam int HIST_DEPTH  = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam int TENSION_W             = 9;
  localparam logic [TENSION_W-1:0] TENSION_RESET = 9'd128;
  localparam int PADDR_W               = 3;
  localparam int PDATA_W               = 32;
  localparam logic REG_TENSION         = 1'b0;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic       echo;
    logic [1:0] channel;
  } cspl_job_ctrl_t;

  localparam int CTRL_W = $bits(cspl_job_ctrl_t);

  typedef struct packed {
    logic [1:0] channel;
    logic       path_start;
    logic       last_of_run;
  } cspl_tag_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] e;
  } cspl_coef_t;

  function automatic cspl_coef_t cspl_coef(input logic [T_W-1:0] t);
    int ti;
    int s;
    cspl_coef_t r;
    ti  = int'(t);
    s   = SEGMENTS;
    r.a = COEF_W'(2 * ti * ti * ti - 3 * ti * ti * s + s * s * s);
    r.b = COEF_W'(3 * ti * ti * s - 2 * ti * ti * ti);
    r.c = COEF_W'(ti * ti * ti - 2 * ti * ti * s + ti * s * s);
    r.e = COEF_W'(ti * ti * ti - ti * ti * s);
    return r;
  endfunction

endpackage

// ===== src/cspl_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspl_queue
// Short register queue of segment and echo jobs between the front and the back.
// ----------------------------------------------------------------------------
module cspl_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cspl_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_stall,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data,
  input  logic             pop_stall
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    push_stall = (count == CNT_W'(DEPTH));
    pop_valid  = (count != '0);
    pop_data   = mem[rd_ptr];
    do_push    = push_valid && !push_stall;
    do_pop     = pop_valid && !pop_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== src/cspl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspl_front
// Accepts point items, keeps the per-channel point history and issues echo
// and segment jobs to the queue.
// ----------------------------------------------------------------------------
module cspl_front #(
  parameter int CHANNELS   = cspl_pkg::CHANNELS_DEF,
  parameter int COORD_BITS = cspl_pkg::COORD_BITS_DEF
) (
  input  logic                                                     clk,
  input  logic                                                     rst,
  input  logic                                                     point_valid,
  output logic                                                     point_stall,
  input  logic                                                     opcode,
  input  logic [1:0]                                               channel,
  input  logic signed [COORD_BITS-1:0]                             x_in,
  input  logic signed [COORD_BITS-1:0]                             y_in,
  output logic                                                     push_valid,
  output logic [cspl_pkg::CTRL_W+cspl_pkg::AXES*cspl_pkg::WIN_PTS*COORD_BITS-1:0] push_data,
  input  logic                                                     push_stall
);
  import cspl_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_TWO  = 2'd2;
  localparam logic [1:0] SEEN_FULL = 2'd3;

  logic [1:0]                  seen [CHANNELS];
  logic signed [COORD_BITS-1:0] hist [CHANNELS][AXES][HIST_DEPTH];
  logic signed [COORD_BITS-1:0] new_pt [AXES];
  logic [CH_W-1:0]             ch_idx;
  logic                        ch_ok;
  logic                        accept;
  logic [1:0]                  cur_seen;
  cspl_job_ctrl_t              ctrl;

  always_comb begin
    ch_idx      = CH_W'(channel);
    ch_ok       = (int'(channel) < CHANNELS);
    point_stall = push_stall;
    accept      = point_valid && !push_stall && ch_ok;
    cur_seen    = seen[ch_idx];
    new_pt[0]   = x_in;
    new_pt[1]   = y_in;
    ctrl.echo    = (cur_seen == SEEN_NONE);
    ctrl.channel = channel;
    push_valid  = point_valid && ch_ok && (opcode == OP_ADD) &&
                  ((cur_seen == SEEN_NONE) || (cur_seen == SEEN_FULL));
    push_data[AXES*WIN_PTS*COORD_BITS +: CTRL_W] = ctrl;
    for (int ax = 0; ax < AXES; ax++) begin
      for (int k = 0; k < WIN_PTS; k++) begin
        if (ctrl.echo || (k == WIN_PTS - 1)) begin
          push_data[(ax*WIN_PTS+k)*COORD_BITS +: COORD_BITS] = new_pt[ax];
        end else begin
          push_data[(ax*WIN_PTS+k)*COORD_BITS +: COORD_BITS] = hist[ch_idx][ax][k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        seen[i] <= SEEN_NONE;
      end
    end else if (accept) begin
      if (opcode == OP_CLEAR) begin
        seen[ch_idx] <= SEEN_NONE;
      end else begin
        unique case (cur_seen)
          SEEN_NONE: seen[ch_idx] <= SEEN_TWO;
          default:   seen[ch_idx] <= SEEN_FULL;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (opcode == OP_ADD)) begin
      for (int ax = 0; ax < AXES; ax++) begin
        unique case (cur_seen)
          SEEN_NONE: begin
            hist[ch_idx][ax][0] <= new_pt[ax];
            hist[ch_idx][ax][1] <= new_pt[ax];
          end
          SEEN_FULL: begin
            hist[ch_idx][ax][0] <= hist[ch_idx][ax][1];
            hist[ch_idx][ax][1] <= hist[ch_idx][ax][2];
            hist[ch_idx][ax][2] <= new_pt[ax];
          end
          default: begin
            hist[ch_idx][ax][2] <= new_pt[ax];
          end
        endcase
      end
    end
  end

endmodule

// ===== src/cspl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspl_back
// Steps t over each job and evaluates the Hermite segment for x and y in a
// stalling pipeline, then rounds, saturates and registers the curve points.
// ----------------------------------------------------------------------------
module cspl_back #(
  parameter int COORD_BITS = cspl_pkg::COORD_BITS_DEF
) (
  input  logic                                                     clk,
  input  logic                                                     rst,
  input  logic [cspl_pkg::TENSION_W-1:0]                           tension,
  input  logic                                                     pop_valid,
  input  logic [cspl_pkg::CTRL_W+cspl_pkg::AXES*cspl_pkg::WIN_PTS*COORD_BITS-1:0] pop_data,
  output logic                                                     pop_stall,
  output logic                                                     curve_valid,
  input  logic                                                     curve_stall,
  output logic [1:0]                                               channel_out,
  output logic signed [COORD_BITS-1:0]                             curve_x,
  output logic signed [COORD_BITS-1:0]                             curve_y,
  output logic                                                     path_start,
  output logic                                                     last_of_run
);
  import cspl_pkg::*;

  localparam int W     = COORD_BITS;
  localparam int DW    = W + 1;
  localparam int MA_W  = W + COEF_W;
  localparam int MC_W  = W + 1 + COEF_W;
  localparam int SAB_W = MA_W + 1;
  localparam int SCE_W = MC_W + 1;
  localparam int TP_W  = SCE_W + TENSION_W + 1;
  localparam int N_W   = TP_W + 1;
  localparam logic signed [N_W-1:0] HALF  = N_W'(1) <<< (DIV_SHIFT - 1);
  localparam logic signed [N_W-1:0] Q_MAX = (N_W'(1) <<< (W - 1)) - N_W'(1);
  localparam logic signed [N_W-1:0] Q_MIN = -(N_W'(1) <<< (W - 1));

  logic                 adv;
  logic                 busy;
  logic [T_W-1:0]       t_cnt;
  logic                 last_issue;
  logic                 pop_take;
  cspl_job_ctrl_t       job_ctrl;
  logic signed [W-1:0]  jp [AXES][WIN_PTS];

  logic                 v1, v2, v3, v4, v5;
  cspl_tag_t            tag1, tag2, tag3, tag4, tag5;
  cspl_coef_t           cf1;
  logic signed [W-1:0]     p1_1 [AXES];
  logic signed [W-1:0]     p2_1 [AXES];
  logic signed [DW-1:0]    d1_1 [AXES];
  logic signed [DW-1:0]    d2_1 [AXES];
  logic signed [MA_W-1:0]  ma_2 [AXES];
  logic signed [MA_W-1:0]  mb_2 [AXES];
  logic signed [MC_W-1:0]  mc_2 [AXES];
  logic signed [MC_W-1:0]  me_2 [AXES];
  logic signed [SAB_W-1:0] sab_3 [AXES];
  logic signed [SCE_W-1:0] sce_3 [AXES];
  logic signed [SAB_W-1:0] sab_4 [AXES];
  logic signed [TP_W-1:0]  tp_4 [AXES];
  logic signed [N_W-1:0]   n_5 [AXES];
  logic signed [N_W-1:0]   q [AXES];
  logic signed [W-1:0]     sat [AXES];
  logic signed [TP_W-1:0]  ten_s;

  always_comb begin
    adv        = !curve_valid || !curve_stall;
    last_issue = busy && (job_ctrl.echo || (t_cnt == T_W'(SEGMENTS)));
    pop_stall  = !(adv && (!busy || last_issue));
    pop_take   = pop_valid && !pop_stall;
    ten_s      = TP_W'({1'b0, tension});
    for (int ax = 0; ax < AXES; ax++) begin
      q[ax] = n_5[ax] >>> DIV_SHIFT;
      if (q[ax] > Q_MAX) begin
        sat[ax] = W'(Q_MAX);
      end else if (q[ax] < Q_MIN) begin
        sat[ax] = W'(Q_MIN);
      end else begin
        sat[ax] = W'(q[ax]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      t_cnt       <= '0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      v4          <= 1'b0;
      v5          <= 1'b0;
      curve_valid <= 1'b0;
    end else begin
      if (pop_take) begin
        busy  <= 1'b1;
        t_cnt <= '0;
      end else if (adv && busy) begin
        if (last_issue) begin
          busy <= 1'b0;
        end else begin
          t_cnt <= t_cnt + T_W'(1);
        end
      end
      if (adv) begin
        v1          <= busy;
        v2          <= v1;
        v3          <= v2;
        v4          <= v3;
        v5          <= v4;
        curve_valid <= v5;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_take) begin
      job_ctrl <= pop_data[AXES*WIN_PTS*W +: CTRL_W];
      for (int ax = 0; ax < AXES; ax++) begin
        for (int k = 0; k < WIN_PTS; k++) begin
          jp[ax][k] <= pop_data[(ax*WIN_PTS+k)*W +: W];
        end
      end
    end
    if (adv) begin
      cf1              <= cspl_coef(t_cnt);
      tag1.channel     <= job_ctrl.channel;
      tag1.path_start  <= job_ctrl.echo;
      tag1.last_of_run <= last_issue;
      tag2             <= tag1;
      tag3             <= tag2;
      tag4             <= tag3;
      tag5             <= tag4;
      for (int ax = 0; ax < AXES; ax++) begin
        p1_1[ax]  <= jp[ax][1];
        p2_1[ax]  <= jp[ax][2];
        d1_1[ax]  <= DW'(jp[ax][2]) - DW'(jp[ax][0]);
        d2_1[ax]  <= DW'(jp[ax][3]) - DW'(jp[ax][1]);
        ma_2[ax]  <= MA_W'(cf1.a) * MA_W'(p1_1[ax]);
        mb_2[ax]  <= MA_W'(cf1.b) * MA_W'(p2_1[ax]);
        mc_2[ax]  <= MC_W'(cf1.c) * MC_W'(d1_1[ax]);
        me_2[ax]  <= MC_W'(cf1.e) * MC_W'(d2_1[ax]);
        sab_3[ax] <= SAB_W'(ma_2[ax]) + SAB_W'(mb_2[ax]);
        sce_3[ax] <= SCE_W'(mc_2[ax]) + SCE_W'(me_2[ax]);
        sab_4[ax] <= sab_3[ax];
        tp_4[ax]  <= TP_W'(sce_3[ax]) * ten_s;
        n_5[ax]   <= (N_W'(sab_4[ax]) <<< FRAC_BITS) + N_W'(tp_4[ax]) + HALF;
      end
      channel_out <= tag5.channel;
      path_start  <= tag5.path_start;
      last_of_run <= tag5.last_of_run;
      curve_x     <= sat[0];
      curve_y     <= sat[1];
    end
  end

endmodule

// ===== src/streaming_cardinal_spline.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// streaming_cardinal_spline
// Per-channel cardinal spline interpolator: point items in, Hermite curve
// points out, tension set over an APB-style register port.
//
//   port group   handshake                  payload
//   point        point_valid / point_stall  opcode, channel, x_in, y_in
//   curve        curve_valid / curve_stall  channel_out, curve_x, curve_y,
//                                           path_start, last_of_run
//   config       psel, penable, pready      pwrite, paddr, pwdata, prdata
//
// A segment item gives 17 curve points, one per cycle from the t sequencer in
// the back while the curve port is not stalled; an echoed first point gives one.
// Clears, second points and ignored channels end at the front and push no job.
// Reset clears the point counts and the pipeline; tension resets to 128.
// A curve stall holds the whole back pipeline; the two-job queue keeps the
// front accepting until it fills.
// ----------------------------------------------------------------------------
module streaming_cardinal_spline #(
  parameter int CHANNELS   = cspl_pkg::CHANNELS_DEF,
  parameter int COORD_BITS = cspl_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               point_valid,
  output logic                               point_stall,
  input  logic                               opcode,
  input  logic [1:0]                         channel,
  input  logic signed [COORD_BITS-1:0]       x_in,
  input  logic signed [COORD_BITS-1:0]       y_in,
  output logic                               curve_valid,
  input  logic                               curve_stall,
  output logic [1:0]                         channel_out,
  output logic signed [COORD_BITS-1:0]       curve_x,
  output logic signed [COORD_BITS-1:0]       curve_y,
  output logic                               path_start,
  output logic                               last_of_run,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cspl_pkg::PADDR_W-1:0]       paddr,
  input  logic [cspl_pkg::PDATA_W-1:0]       pwdata,
  output logic [cspl_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);
  import cspl_pkg::*;

  localparam int JOB_W = CTRL_W + AXES * WIN_PTS * COORD_BITS;

  logic [TENSION_W-1:0] tension;
  logic                 push_valid;
  logic [JOB_W-1:0]     push_data;
  logic                 push_stall;
  logic                 pop_valid;
  logic [JOB_W-1:0]     pop_data;
  logic                 pop_stall;

  always_comb begin
    pready = 1'b1;
    prdata = (paddr[2] == REG_TENSION) ? PDATA_W'(tension) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tension <= TENSION_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TENSION)) begin
      tension <= pwdata[TENSION_W-1:0];
    end
  end

  cspl_front #(
    .CHANNELS   (CHANNELS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .opcode      (opcode),
    .channel     (channel),
    .x_in        (x_in),
    .y_in        (y_in),
    .push_valid  (push_valid),
    .push_data   (push_data),
    .push_stall  (push_stall)
  );

  cspl_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_stall (push_stall),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_stall  (pop_stall)
  );

  cspl_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .tension     (tension),
    .pop_valid   (pop_valid),
    .pop_data    (pop_data),
    .pop_stall   (pop_stall),
    .curve_valid (curve_valid),
    .curve_stall (curve_stall),
    .channel_out (channel_out),
    .curve_x     (curve_x),
    .curve_y     (curve_y),
    .path_start  (path_start),
    .last_of_run (last_of_run)
  );

endmodule

// ===== src/cspl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspl_checker
// Port-level checks of the cardinal spline interpolator, bound to the top.
// ----------------------------------------------------------------------------
module cspl_checker #(
  parameter int COORD_BITS = cspl_pkg::COORD_BITS_DEF
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               curve_valid,
  input logic                               curve_stall,
  input logic [1:0]                         channel_out,
  input logic signed [COORD_BITS-1:0]       curve_x,
  input logic signed [COORD_BITS-1:0]       curve_y,
  input logic                               path_start,
  input logic                               last_of_run,
  input logic                               psel,
  input logic                               penable,
  input logic                               pwrite,
  input logic [cspl_pkg::PADDR_W-1:0]       paddr,
  input logic [cspl_pkg::PDATA_W-1:0]       pwdata,
  input logic [cspl_pkg::PDATA_W-1:0]       prdata,
  input logic                               pready
);
  import cspl_pkg::*;

  a_curve_hold: assert property (@(posedge clk) disable iff (rst)
    curve_valid && curve_stall |=> curve_valid && $stable(curve_x) &&
      $stable(curve_y) && $stable(channel_out) && $stable(path_start) &&
      $stable(last_of_run))
    else $error("stalled curve item changed");

  a_start_is_last: assert property (@(posedge clk) disable iff (rst)
    curve_valid && path_start |-> last_of_run)
    else $error("path start item not marked last of run");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !curve_valid)
    else $error("curve item shown right after reset");

  a_tension_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && (paddr[2] == REG_TENSION)) ##1
      (paddr[2] == REG_TENSION)
    |-> prdata[TENSION_W-1:0] == $past(pwdata[TENSION_W-1:0]))
    else $error("tension readback mismatch");

endmodule

bind streaming_cardinal_spline cspl_checker #(.COORD_BITS(COORD_BITS)) u_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming cardinal spline interpolator. Point
// items go in on four channels and the curve points that come out are checked
// against a bit-accurate Hermite predictor. Tension is rewritten over the
// register port between phases. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import cspl_pkg::*;

  localparam int CW           = COORD_BITS_DEF;
  localparam int NCH          = CHANNELS_DEF;
  localparam int WATCHDOG     = 4000;
  localparam int DRAIN_CYCLES = 24;
  localparam int PHASE_ITEMS  = 70;
  localparam logic [PADDR_W-1:0] TENSION_ADDR = PADDR_W'(4 * REG_TENSION);
  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic [1:0]           ch;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 start;
    logic                 last;
  } curve_pt_t;

  class spline_scoreboard;
    logic [TENSION_W-1:0] tension;
    logic signed [CW-1:0] hist_x[NCH][HIST_DEPTH];
    logic signed [CW-1:0] hist_y[NCH][HIST_DEPTH];
    int                   stored[NCH];
    curve_pt_t            awaited[$];
    int                   fails;

    function new();
      tension = TENSION_RESET;
      fails   = 0;
      for (int c = 0; c < NCH; c++) begin
        stored[c] = 0;
        for (int k = 0; k < HIST_DEPTH; k++) begin
          hist_x[c][k] = '0;
          hist_y[c][k] = '0;
        end
      end
    endfunction

    task flag(input string msg);
      $display("mismatch @%0t: %s", $time, msg);
      fails++;
    endtask

    function int pending();
      return awaited.size();
    endfunction

    function logic signed [CW-1:0] blend(input longint p0, input longint p1,
                                         input longint p2, input longint p3,
                                         input longint t);
      longint s, d, a, b, c, e, n, q;
      s = SEGMENTS;
      d = 256 * s * s * s;
      a = 2 * t * t * t - 3 * t * t * s + s * s * s;
      b = 3 * t * t * s - 2 * t * t * t;
      c = t * t * t - 2 * t * t * s + t * s * s;
      e = t * t * t - t * t * s;
      n = 256 * (a * p1 + b * p2) + longint'({55'd0, tension}) * (c * (p2 - p0) + e * (p3 - p1));
      n = n + d / 2;
      q = n / d;
      if (n % d != 0 && n < 0) q = q - 1;
      if (q > longint'(COORD_MAX)) q = longint'(COORD_MAX);
      if (q < longint'(COORD_MIN)) q = longint'(COORD_MIN);
      return CW'(q);
    endfunction

    function void note_point(input logic op, input logic [1:0] ch,
                             input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
      curve_pt_t pt;
      if (op == OP_CLEAR) begin
        stored[ch] = 0;
        return;
      end
      if (stored[ch] == 0) begin
        hist_x[ch][0] = x;
        hist_y[ch][0] = y;
        hist_x[ch][1] = x;
        hist_y[ch][1] = y;
        stored[ch] = 2;
        pt = '{ch: ch, x: x, y: y, start: 1'b1, last: 1'b1};
        awaited.push_back(pt);
      end else if (stored[ch] < HIST_DEPTH) begin
        hist_x[ch][2] = x;
        hist_y[ch][2] = y;
        stored[ch] = HIST_DEPTH;
      end else begin
        for (int t = 0; t <= SEGMENTS; t++) begin
          pt.ch    = ch;
          pt.x     = blend(hist_x[ch][0], hist_x[ch][1], hist_x[ch][2], x, t);
          pt.y     = blend(hist_y[ch][0], hist_y[ch][1], hist_y[ch][2], y, t);
          pt.start = 1'b0;
          pt.last  = (t == SEGMENTS);
          awaited.push_back(pt);
        end
        hist_x[ch][0] = hist_x[ch][1];
        hist_y[ch][0] = hist_y[ch][1];
        hist_x[ch][1] = hist_x[ch][2];
        hist_y[ch][1] = hist_y[ch][2];
        hist_x[ch][2] = x;
        hist_y[ch][2] = y;
      end
    endfunction

    task check_curve(input curve_pt_t got);
      curve_pt_t want;
      if (awaited.size() == 0) begin
        flag($sformatf("curve item ch%0d x=%0d y=%0d with nothing awaited",
                       got.ch, got.x, got.y));
        return;
      end
      want = awaited.pop_front();
      if (got.ch != want.ch)
        flag($sformatf("channel_out %0d, want %0d", got.ch, want.ch));
      if (got.x != want.x)
        flag($sformatf("ch%0d curve_x %0d, want %0d", want.ch, got.x, want.x));
      if (got.y != want.y)
        flag($sformatf("ch%0d curve_y %0d, want %0d", want.ch, got.y, want.y));
      if (got.start != want.start)
        flag($sformatf("ch%0d path_start %0b, want %0b", want.ch, got.start, want.start));
      if (got.last != want.last)
        flag($sformatf("ch%0d last_of_run %0b, want %0b", want.ch, got.last, want.last));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 point_valid = 1'b0;
  logic                 point_stall;
  logic                 opcode = OP_ADD;
  logic [1:0]           channel = '0;
  logic signed [CW-1:0] x_in = '0;
  logic signed [CW-1:0] y_in = '0;
  logic                 curve_valid;
  logic                 curve_stall = 1'b0;
  logic [1:0]           channel_out;
  logic signed [CW-1:0] curve_x;
  logic signed [CW-1:0] curve_y;
  logic                 path_start;
  logic                 last_of_run;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  spline_scoreboard     sb = new();
  int                   idle_in = 0;
  int                   stall_out = 0;
  int                   quiet_cycles = 0;
  logic signed [CW-1:0] walk_x[NCH];
  logic signed [CW-1:0] walk_y[NCH];

  streaming_cardinal_spline dut (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .opcode      (opcode),
    .channel     (channel),
    .x_in        (x_in),
    .y_in        (y_in),
    .curve_valid (curve_valid),
    .curve_stall (curve_stall),
    .channel_out (channel_out),
    .curve_x     (curve_x),
    .curve_y     (curve_y),
    .path_start  (path_start),
    .last_of_run (last_of_run),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    curve_stall <= rst ? 1'b0 : ($urandom_range(99) < stall_out);
  end

  always @(posedge clk) begin
    if (!rst && curve_valid && !curve_stall)
      sb.check_curve('{ch: channel_out, x: curve_x, y: curve_y,
                       start: path_start, last: last_of_run});
  end

  always @(posedge clk) begin
    if (rst || (point_valid && !point_stall) || (curve_valid && !curve_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_point(input logic op, input logic [1:0] ch,
                            input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
    while ($urandom_range(99) < idle_in) begin
      point_valid <= 1'b0;
      @(posedge clk);
    end
    point_valid <= 1'b1;
    opcode      <= op;
    channel     <= ch;
    x_in        <= x;
    y_in        <= y;
    @(posedge clk);
    while (point_stall) @(posedge clk);
    sb.note_point(op, ch, x, y);
  endtask

  task automatic drain();
    point_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic read_tension();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= TENSION_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata != PDATA_W'(sb.tension))
      sb.flag($sformatf("tension reads %0d, want %0d", prdata, sb.tension));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_tension(input logic [TENSION_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TENSION_ADDR;
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.tension = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    read_tension();
  endtask

  function automatic logic signed [CW-1:0] pick_coord(input logic signed [CW-1:0] base);
    int mode;
    mode = $urandom_range(9);
    if (mode < 2) return CW'($urandom);
    if (mode == 2) begin
      case ($urandom_range(3))
        0: return COORD_MAX;
        1: return COORD_MIN;
        2: return '0;
        default: return '1;
      endcase
    end
    return base + CW'($signed($urandom_range(8191)) - 4096);
  endfunction

  task automatic random_points(input int count);
    logic                 op;
    logic [1:0]           ch;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    repeat (count) begin
      op = ($urandom_range(99) < 8) ? OP_CLEAR : OP_ADD;
      ch = 2'($urandom_range(NCH - 1));
      x  = pick_coord(walk_x[ch]);
      y  = pick_coord(walk_y[ch]);
      if (op == OP_ADD) begin
        walk_x[ch] = x;
        walk_y[ch] = y;
      end
      send_point(op, ch, x, y);
    end
  endtask

  initial begin
    for (int c = 0; c < NCH; c++) begin
      walk_x[c] = CW'($urandom);
      walk_y[c] = CW'($urandom);
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    read_tension();

    idle_in   = 14;
    stall_out = 80;
    // full-scale swings overshoot and saturate
    send_point(OP_ADD,   2'd0, COORD_MAX, COORD_MIN);
    send_point(OP_ADD,   2'd0, COORD_MIN, COORD_MAX);
    send_point(OP_ADD,   2'd0, COORD_MAX, COORD_MIN);
    send_point(OP_ADD,   2'd0, COORD_MAX, COORD_MIN);
    send_point(OP_ADD,   2'd0, COORD_MIN, COORD_MAX);
    send_point(OP_ADD,   2'd0, '0, '1);
    send_point(OP_CLEAR, 2'd0, COORD_MAX, COORD_MAX);
    send_point(OP_ADD,   2'd0, '1, 24'sd1);
    // interleaved channels
    send_point(OP_ADD,   2'd1, 24'sd256, -24'sd256);
    send_point(OP_ADD,   2'd2, -24'sd3, 24'sd5);
    send_point(OP_ADD,   2'd1, 24'sd512, 24'sd128);
    send_point(OP_ADD,   2'd3, COORD_MIN, COORD_MIN);
    send_point(OP_ADD,   2'd1, 24'sd1024, 24'sd1024);
    send_point(OP_ADD,   2'd2, 24'sd7, -24'sd9);
    send_point(OP_ADD,   2'd1, 24'sd1, -24'sd1);
    send_point(OP_ADD,   2'd2, 24'sd100, 24'sd50);
    // clear after echo only, clear of an empty channel
    send_point(OP_CLEAR, 2'd3, '0, '0);
    send_point(OP_CLEAR, 2'd3, '1, '1);
    send_point(OP_ADD,   2'd3, COORD_MAX, COORD_MAX);
    send_point(OP_ADD,   2'd3, COORD_MAX, COORD_MAX);
    send_point(OP_ADD,   2'd3, COORD_MAX, COORD_MAX);
    send_point(OP_CLEAR, 2'd1, '0, '0);
    send_point(OP_ADD,   2'd1, 24'sh555555, 24'shAAAAAA);
    drain();

    write_tension(9'd511);
    random_points(PHASE_ITEMS);
    drain();

    idle_in   = 80;
    stall_out = 14;
    write_tension(9'd0);
    random_points(PHASE_ITEMS);
    drain();

    idle_in   = 0;
    stall_out = 0;
    write_tension(9'd256);
    random_points(PHASE_ITEMS / 2);
    drain();

    write_tension(TENSION_W'($urandom_range(1, 510)));
    random_points(PHASE_ITEMS / 2);
    drain();

    if (sb.fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/cspl_pkg.sv
src/cspl_queue.sv
src/cspl_front.sv
src/cspl_back.sv
src/streaming_cardinal_spline.sv
src/cspl_checker.sv
tb/tb_top.sv
